[sv/mau_pkg.sv]
// ============================================================================
// mau_pkg: shared types and microcode for the modular arithmetic unit
// Holds command codes, the micro-op and branch-condition codes, the control
// word layout and the read-only microprogram that sequences the datapath.
// ============================================================================
package mau_pkg;

    // Defaults for the top-level parameters
    localparam int VALUE_BITS_DEF    = 8;
    localparam int EXPONENT_BITS_DEF = 16;

    // Fixed interface widths
    localparam int CMD_W   = 3;
    localparam int FLAG_W  = 3;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam int unsigned MODULUS_RESET = 239;

    // Register index, taken from paddr[APB_AW-1:2]
    localparam logic [APB_AW-3:0] REG_MODULUS = '0;

    // Result flag positions in the output tuser
    localparam int FLAG_NO_INV = 0;
    localparam int FLAG_EQUAL  = 1;
    localparam int FLAG_LESS   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_POW = 3'd4,
        CMD_INV = 3'd5
    } t_cmd;

    // Datapath actions, one per control word
    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,       // wait for an input beat and latch it
        U_LD_DIV_A,   // divider: raw a by modulus
        U_LD_DIV_B,   // divider: raw b by modulus
        U_LD_DIV_E,   // divider: r0 by r1
        U_DIV,        // one quotient bit per cycle
        U_MV_RA,
        U_MV_RB,
        U_LD_MUL_AB,  // multiplier: a * b
        U_LD_MUL_AI,  // multiplier: a * t0 (inverse)
        U_LD_MUL_QT,  // multiplier: quotient * t1
        U_LD_MUL_ACC, // multiplier: acc * base
        U_LD_MUL_SQ,  // multiplier: base * base
        U_MUL,        // one multiplier bit per cycle
        U_MV_RES,
        U_MV_ACC,
        U_MV_BASE,
        U_EU_INIT_A,  // Euclid on a
        U_EU_INIT_B,  // Euclid on b
        U_EU_STEP,
        U_PW_INIT,
        U_BASE_INV,
        U_EXP_SHR,
        U_RES_ADD,
        U_RES_SUB,
        U_RES_INV,
        U_RES_ACC,
        U_RES_ZERO,
        U_SET_ERR,
        U_DONE        // hand the result to the output register
    } t_uop;

    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_DISPATCH,
        C_R1_ZERO,
        C_R0_NE1,
        C_IS_INV,
        C_IS_POW,
        C_EXP_POS,
        C_E_ZERO,
        C_E_EVEN
    } t_cond;

    localparam int PC_W = 6;
    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Program addresses
    localparam t_pc S_IDLE     = 6'd0;
    localparam t_pc S_RA_LD    = 6'd1;
    localparam t_pc S_RA_DIV   = 6'd2;
    localparam t_pc S_RA_MV    = 6'd3;
    localparam t_pc S_RB_LD    = 6'd4;
    localparam t_pc S_RB_DIV   = 6'd5;
    localparam t_pc S_RB_MV    = 6'd6;
    localparam t_pc S_ADD      = 6'd7;
    localparam t_pc S_SUB      = 6'd8;
    localparam t_pc S_MUL_LD   = 6'd9;
    localparam t_pc S_MUL_RUN  = 6'd10;
    localparam t_pc S_MUL_MV   = 6'd11;
    localparam t_pc S_DIV_INIT = 6'd12;
    localparam t_pc S_INV_INIT = 6'd13;
    localparam t_pc S_POW_INIT = 6'd14;
    localparam t_pc S_POW_INV  = 6'd15;
    localparam t_pc S_NOP_CMD  = 6'd16;
    localparam t_pc S_EU_TEST  = 6'd17;
    localparam t_pc S_EU_DLD   = 6'd18;
    localparam t_pc S_EU_DIV   = 6'd19;
    localparam t_pc S_EU_MLD   = 6'd20;
    localparam t_pc S_EU_MUL   = 6'd21;
    localparam t_pc S_EU_STEP  = 6'd22;
    localparam t_pc S_EU_END   = 6'd23;
    localparam t_pc S_EU_INV   = 6'd24;
    localparam t_pc S_EU_POW   = 6'd25;
    localparam t_pc S_QT_LD    = 6'd26;
    localparam t_pc S_QT_MUL   = 6'd27;
    localparam t_pc S_QT_MV    = 6'd28;
    localparam t_pc S_INV_RES  = 6'd29;
    localparam t_pc S_POW_BASE = 6'd30;
    localparam t_pc S_PW_TEST  = 6'd31;
    localparam t_pc S_PW_ODD   = 6'd32;
    localparam t_pc S_PW_MLD   = 6'd33;
    localparam t_pc S_PW_MUL   = 6'd34;
    localparam t_pc S_PW_MMV   = 6'd35;
    localparam t_pc S_PW_SLD   = 6'd36;
    localparam t_pc S_PW_SQR   = 6'd37;
    localparam t_pc S_PW_SMV   = 6'd38;
    localparam t_pc S_PW_SHR   = 6'd39;
    localparam t_pc S_PW_END   = 6'd40;
    localparam t_pc S_ERR      = 6'd41;
    localparam t_pc S_DONE     = 6'd42;

    // Microprogram ROM
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{U_NOP, C_JUMP, S_IDLE};
        case (pc)
            // reduce both operands, then branch on the command
            S_IDLE:     w = '{U_LOAD,       C_NEXT,     S_IDLE};
            S_RA_LD:    w = '{U_LD_DIV_A,   C_NEXT,     S_IDLE};
            S_RA_DIV:   w = '{U_DIV,        C_NEXT,     S_IDLE};
            S_RA_MV:    w = '{U_MV_RA,      C_NEXT,     S_IDLE};
            S_RB_LD:    w = '{U_LD_DIV_B,   C_NEXT,     S_IDLE};
            S_RB_DIV:   w = '{U_DIV,        C_NEXT,     S_IDLE};
            S_RB_MV:    w = '{U_MV_RB,      C_DISPATCH, S_IDLE};
            // command entry points
            S_ADD:      w = '{U_RES_ADD,    C_JUMP,     S_DONE};
            S_SUB:      w = '{U_RES_SUB,    C_JUMP,     S_DONE};
            S_MUL_LD:   w = '{U_LD_MUL_AB,  C_NEXT,     S_IDLE};
            S_MUL_RUN:  w = '{U_MUL,        C_NEXT,     S_IDLE};
            S_MUL_MV:   w = '{U_MV_RES,     C_JUMP,     S_DONE};
            S_DIV_INIT: w = '{U_EU_INIT_B,  C_JUMP,     S_EU_TEST};
            S_INV_INIT: w = '{U_EU_INIT_A,  C_JUMP,     S_EU_TEST};
            S_POW_INIT: w = '{U_PW_INIT,    C_EXP_POS,  S_PW_TEST};
            S_POW_INV:  w = '{U_EU_INIT_A,  C_JUMP,     S_EU_TEST};
            S_NOP_CMD:  w = '{U_RES_ZERO,   C_JUMP,     S_DONE};
            // extended Euclid, cofactor kept as a residue
            S_EU_TEST:  w = '{U_NOP,        C_R1_ZERO,  S_EU_END};
            S_EU_DLD:   w = '{U_LD_DIV_E,   C_NEXT,     S_IDLE};
            S_EU_DIV:   w = '{U_DIV,        C_NEXT,     S_IDLE};
            S_EU_MLD:   w = '{U_LD_MUL_QT,  C_NEXT,     S_IDLE};
            S_EU_MUL:   w = '{U_MUL,        C_NEXT,     S_IDLE};
            S_EU_STEP:  w = '{U_EU_STEP,    C_JUMP,     S_EU_TEST};
            S_EU_END:   w = '{U_NOP,        C_R0_NE1,   S_ERR};
            S_EU_INV:   w = '{U_NOP,        C_IS_INV,   S_INV_RES};
            S_EU_POW:   w = '{U_NOP,        C_IS_POW,   S_POW_BASE};
            // divide: a times the inverse of b
            S_QT_LD:    w = '{U_LD_MUL_AI,  C_NEXT,     S_IDLE};
            S_QT_MUL:   w = '{U_MUL,        C_NEXT,     S_IDLE};
            S_QT_MV:    w = '{U_MV_RES,     C_JUMP,     S_DONE};
            S_INV_RES:  w = '{U_RES_INV,    C_JUMP,     S_DONE};
            // square-and-multiply, low exponent bit first
            S_POW_BASE: w = '{U_BASE_INV,   C_NEXT,     S_IDLE};
            S_PW_TEST:  w = '{U_NOP,        C_E_ZERO,   S_PW_END};
            S_PW_ODD:   w = '{U_NOP,        C_E_EVEN,   S_PW_SLD};
            S_PW_MLD:   w = '{U_LD_MUL_ACC, C_NEXT,     S_IDLE};
            S_PW_MUL:   w = '{U_MUL,        C_NEXT,     S_IDLE};
            S_PW_MMV:   w = '{U_MV_ACC,     C_NEXT,     S_IDLE};
            S_PW_SLD:   w = '{U_LD_MUL_SQ,  C_NEXT,     S_IDLE};
            S_PW_SQR:   w = '{U_MUL,        C_NEXT,     S_IDLE};
            S_PW_SMV:   w = '{U_MV_BASE,    C_NEXT,     S_IDLE};
            S_PW_SHR:   w = '{U_EXP_SHR,    C_JUMP,     S_PW_TEST};
            S_PW_END:   w = '{U_RES_ACC,    C_JUMP,     S_DONE};
            // wrap up
            S_ERR:      w = '{U_SET_ERR,    C_NEXT,     S_IDLE};
            S_DONE:     w = '{U_DONE,       C_JUMP,     S_IDLE};
            default:    w = '{U_NOP,        C_JUMP,     S_IDLE};
        endcase
        return w;
    endfunction

    // Entry point for each command
    function automatic t_pc dispatch(input logic [CMD_W-1:0] cmd);
        t_pc pc;
        case (cmd)
            CMD_ADD: pc = S_ADD;
            CMD_SUB: pc = S_SUB;
            CMD_MUL: pc = S_MUL_LD;
            CMD_DIV: pc = S_DIV_INIT;
            CMD_POW: pc = S_POW_INIT;
            CMD_INV: pc = S_INV_INIT;
            default: pc = S_NOP_CMD;
        endcase
        return pc;
    endfunction

endpackage

[sv/modular_arithmetic_unit.sv]
// ============================================================================
// modular_arithmetic_unit: residue arithmetic modulo a programmable modulus
// Microcoded sequencer over a shared bit-serial divider and a bit-serial
// modular multiplier; add, subtract, multiply, divide, power and inverse.
// ============================================================================
// One item is worked on at a time, and the next beat is taken once the
// result has moved to the output register, even while that result still
// waits for the sink; until then a full output register holds the
// sequencer on its last step. The divider and the multiplier each retire
// one bit per cycle. Each item first has both operands reduced by the
// divider; add, subtract and the unused codes then finish directly, and
// multiply runs the multiplier once. Inverse and divide run extended
// Euclid (at most about 1.5*V steps for V-bit values, V = VALUE_BITS),
// and divide then multiplies by the inverse. Power runs a multiply and a
// square on each set bit and a square on each clear bit up to the highest
// set bit of the exponent magnitude, after an inverse for a negative
// exponent.
// The modulus register is at byte address 0; values 0 and 1 act as 2.
module modular_arithmetic_unit #(
    parameter int VALUE_BITS    = mau_pkg::VALUE_BITS_DEF,
    parameter int EXPONENT_BITS = mau_pkg::EXPONENT_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    // APB configuration port
    input  logic                                               psel,
    input  logic                                               penable,
    input  logic                                               pwrite,
    input  logic [mau_pkg::APB_AW-1:0]                         paddr,
    input  logic [mau_pkg::APB_DW-1:0]                         pwdata,
    output logic [mau_pkg::APB_DW-1:0]                         prdata,
    output logic                                               pready,
    // input stream
    input  logic                                               s_axis_tvalid,
    output logic                                               s_axis_tready,
    // tdata: operand_a, operand_b, exponent (signed), zero padding
    input  logic [((2*VALUE_BITS+EXPONENT_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: command
    input  logic [mau_pkg::CMD_W-1:0]                          s_axis_tuser,
    // output stream
    output logic                                               m_axis_tvalid,
    input  logic                                               m_axis_tready,
    // tdata: result_value, zero padding
    output logic [((VALUE_BITS+7)/8)*8-1:0]                    m_axis_tdata,
    // tuser: no_inverse, operands_equal, a_less_than_b
    output logic [mau_pkg::FLAG_W-1:0]                         m_axis_tuser
);
    import mau_pkg::*;

    localparam int VB     = VALUE_BITS;
    localparam int EB     = EXPONENT_BITS;
    localparam int OUT_DW = ((VB + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(VB);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [VB-1:0] r_modulus;
    logic [VB-1:0] m_eff;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1:2] == REG_MODULUS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= VB'(MODULUS_RESET);
        end else if (cfg_wr) begin
            r_modulus <= pwdata[VB-1:0];
        end
    end

    // Return the register on a hit, zero elsewhere
    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1:2] == REG_MODULUS) begin
            prdata = APB_DW'(r_modulus);
        end
    end

    // Treat moduli below two as two
    assign m_eff = (r_modulus < VB'(2)) ? VB'(2) : r_modulus;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_pc              r_pc;
    t_pc              n_pc;
    t_uword           uw;
    logic [CNT_W-1:0] r_cnt;
    logic             cnt_last;
    logic             is_iter;
    logic             adv;
    logic             take;
    logic             in_accept;
    logic             out_free;
    logic             r_out_valid;

    // datapath registers referenced by branch conditions
    logic [CMD_W-1:0] r_cmd;
    logic [VB-1:0]    r_r0;
    logic [VB-1:0]    r_r1;
    logic [EB-1:0]    r_exp;
    logic             r_exp_neg;

    assign uw        = ucode(r_pc);
    assign is_iter   = (uw.op == U_DIV) || (uw.op == U_MUL);
    assign cnt_last  = (r_cnt == CNT_W'(VB - 1));
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (uw.op == U_LOAD);

    // Hold on waits and serial ops, otherwise branch or fall through
    always_comb begin
        adv = 1'b1;
        if (uw.op == U_LOAD) begin
            adv = s_axis_tvalid;
        end else if (is_iter) begin
            adv = cnt_last;
        end else if (uw.op == U_DONE) begin
            adv = out_free;
        end

        take = 1'b0;
        case (uw.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_DISPATCH: take = 1'b1;
            C_R1_ZERO:  take = (r_r1 == '0);
            C_R0_NE1:   take = (r_r0 != VB'(1));
            C_IS_INV:   take = (r_cmd == CMD_INV);
            C_IS_POW:   take = (r_cmd == CMD_POW);
            C_EXP_POS:  take = !r_exp_neg;
            C_E_ZERO:   take = (r_exp == '0);
            C_E_EVEN:   take = !r_exp[0];
            default:    take = 1'b0;
        endcase

        if (!adv) begin
            n_pc = r_pc;
        end else if (take && (uw.cond == C_DISPATCH)) begin
            n_pc = dispatch(r_cmd);
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // Advance step counter, bit counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (is_iter) begin
                r_cnt <= cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            if ((uw.op == U_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [VB-1:0]    r_a_in;
    logic [VB-1:0]    r_b_in;
    logic [VB-1:0]    r_ra;
    logic [VB-1:0]    r_rb;
    logic [VB-1:0]    r_dvd;
    logic [VB-1:0]    r_dvs;
    logic [VB-1:0]    r_rem;
    logic [VB-1:0]    r_mx;
    logic [VB-1:0]    r_my;
    logic [VB-1:0]    r_macc;
    logic [VB-1:0]    r_t0;
    logic [VB-1:0]    r_t1;
    logic [VB-1:0]    r_acc;
    logic [VB-1:0]    r_base;
    logic [VB-1:0]    r_res;
    logic             r_err;
    logic [VB-1:0]    r_out_value;
    logic [FLAG_W-1:0] r_out_flags;

    logic [EB-1:0]    in_exp;
    logic [EB-1:0]    in_mag;
    logic [VB:0]      div_try;
    logic             div_ge;
    logic [VB-1:0]    div_rem;
    logic [VB+1:0]    mul_s0;
    logic [VB+1:0]    mul_s1;
    logic [VB+1:0]    mul_s2;
    logic [VB:0]      add_s;
    logic [VB-1:0]    add_res;
    logic [VB:0]      sub_s;
    logic [VB-1:0]    sub_res;
    logic [VB:0]      t_s;
    logic [VB-1:0]    t_new;

    // Exponent magnitude for the power loop
    assign in_exp = s_axis_tdata[2*VB +: EB];
    assign in_mag = in_exp[EB-1] ? (~in_exp + EB'(1)) : in_exp;

    // Restoring divider step
    assign div_try = {r_rem, r_dvd[VB-1]};
    assign div_ge  = (div_try >= {1'b0, r_dvs});
    assign div_rem = div_ge ? VB'(div_try - {1'b0, r_dvs}) : div_try[VB-1:0];

    // Interleaved modular multiply step: 2*acc + bit*y, fold twice
    always_comb begin
        mul_s0 = {1'b0, r_macc, 1'b0} + (r_mx[VB-1] ? {2'b00, r_my} : '0);
        mul_s1 = (mul_s0 >= {2'b00, m_eff}) ? mul_s0 - {2'b00, m_eff} : mul_s0;
        mul_s2 = (mul_s1 >= {2'b00, m_eff}) ? mul_s1 - {2'b00, m_eff} : mul_s1;
    end

    // Modular add and subtract of the reduced operands
    assign add_s   = {1'b0, r_ra} + {1'b0, r_rb};
    assign add_res = (add_s >= {1'b0, m_eff}) ? VB'(add_s - {1'b0, m_eff})
                                              : add_s[VB-1:0];
    assign sub_s   = {1'b0, r_ra} + {1'b0, m_eff} - {1'b0, r_rb};
    assign sub_res = (sub_s >= {1'b0, m_eff}) ? VB'(sub_s - {1'b0, m_eff})
                                              : sub_s[VB-1:0];

    // Cofactor update t0 - q*t1 as a residue
    assign t_s   = {1'b0, r_t0} + {1'b0, m_eff} - {1'b0, r_macc};
    assign t_new = (t_s >= {1'b0, m_eff}) ? VB'(t_s - {1'b0, m_eff}) : t_s[VB-1:0];

    // Execute the current control word
    always_ff @(posedge i_clk) begin
        case (uw.op)
            U_LOAD: begin
                if (in_accept) begin
                    r_cmd     <= s_axis_tuser;
                    r_a_in    <= s_axis_tdata[0 +: VB];
                    r_b_in    <= s_axis_tdata[VB +: VB];
                    r_exp     <= in_mag;
                    r_exp_neg <= in_exp[EB-1];
                    r_err     <= 1'b0;
                end
            end
            U_LD_DIV_A: begin
                r_dvd <= r_a_in;
                r_dvs <= m_eff;
                r_rem <= '0;
            end
            U_LD_DIV_B: begin
                r_dvd <= r_b_in;
                r_dvs <= m_eff;
                r_rem <= '0;
            end
            U_LD_DIV_E: begin
                r_dvd <= r_r0;
                r_dvs <= r_r1;
                r_rem <= '0;
            end
            U_DIV: begin
                r_rem <= div_rem;
                r_dvd <= {r_dvd[VB-2:0], div_ge};
            end
            U_MV_RA: r_ra <= r_rem;
            U_MV_RB: r_rb <= r_rem;
            U_LD_MUL_AB: begin
                r_mx   <= r_ra;
                r_my   <= r_rb;
                r_macc <= '0;
            end
            U_LD_MUL_AI: begin
                r_mx   <= r_ra;
                r_my   <= r_t0;
                r_macc <= '0;
            end
            U_LD_MUL_QT: begin
                r_mx   <= r_dvd;
                r_my   <= r_t1;
                r_macc <= '0;
            end
            U_LD_MUL_ACC: begin
                r_mx   <= r_acc;
                r_my   <= r_base;
                r_macc <= '0;
            end
            U_LD_MUL_SQ: begin
                r_mx   <= r_base;
                r_my   <= r_base;
                r_macc <= '0;
            end
            U_MUL: begin
                r_macc <= mul_s2[VB-1:0];
                r_mx   <= {r_mx[VB-2:0], 1'b0};
            end
            U_MV_RES:  r_res  <= r_macc;
            U_MV_ACC:  r_acc  <= r_macc;
            U_MV_BASE: r_base <= r_macc;
            U_EU_INIT_A: begin
                r_r0 <= m_eff;
                r_r1 <= r_ra;
                r_t0 <= '0;
                r_t1 <= VB'(1);
            end
            U_EU_INIT_B: begin
                r_r0 <= m_eff;
                r_r1 <= r_rb;
                r_t0 <= '0;
                r_t1 <= VB'(1);
            end
            U_EU_STEP: begin
                r_r0 <= r_r1;
                r_r1 <= r_rem;
                r_t0 <= r_t1;
                r_t1 <= t_new;
            end
            U_PW_INIT: begin
                r_acc  <= VB'(1);
                r_base <= r_ra;
            end
            U_BASE_INV: r_base <= r_t0;
            U_EXP_SHR:  r_exp  <= r_exp >> 1;
            U_RES_ADD:  r_res  <= add_res;
            U_RES_SUB:  r_res  <= sub_res;
            U_RES_INV:  r_res  <= r_t0;
            U_RES_ACC:  r_res  <= r_acc;
            U_RES_ZERO: r_res  <= '0;
            U_SET_ERR: begin
                r_err <= 1'b1;
                r_res <= '0;
            end
            U_DONE: begin
                if (out_free) begin
                    r_out_value              <= r_res;
                    r_out_flags[FLAG_NO_INV] <= r_err;
                    r_out_flags[FLAG_EQUAL]  <= (r_ra == r_rb);
                    r_out_flags[FLAG_LESS]   <= (r_ra < r_rb);
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_value);
    assign m_axis_tuser  = r_out_flags;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input taken again right after a beat");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[FLAG_NO_INV] |-> (r_out_value == '0))
        else $error("missing inverse with nonzero result");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[FLAG_EQUAL] && m_axis_tuser[FLAG_LESS]))
        else $error("equal and less-than both set");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_iter |-> (r_cnt == '0))
        else $error("bit counter running outside a serial step");

endmodule

[tb/modular_arithmetic_unit_tb.sv]
// ============================================================================
// modular_arithmetic_unit_tb: self-checking bench for the residue ALU
// Drives command beats over the input stream and the modulus over APB,
// predicts every result (residue, no_inverse and compare flags) and checks each output
// beat in order. Runs directed corner items, then random items over several
// moduli, with bursty input, random output stalls and one long hold-off.
// ============================================================================
module modular_arithmetic_unit_tb;
    import mau_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int EB          = EXPONENT_BITS_DEF;
    localparam int IN_W        = ((2*VB+EB+7)/8)*8;
    localparam int OUT_W       = ((VB+7)/8)*8;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int PER_PHASE   = 40;
    localparam int NUM_PHASES  = 10;
    localparam int DRAIN_WAIT  = 40;

    localparam logic [APB_AW-1:0] MODULUS_ADDR = {REG_MODULUS, 2'b00};
    // command codes that select no operation
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [VB-1:0] value;
        logic          no_inv;
        logic          equal;
        logic          less;
    } t_residue_result;

    // ------------------------------------------------------------------------
    // Result predictor and in-order checker
    // ------------------------------------------------------------------------
    class residue_scoreboard;
        logic [VB-1:0]   modulus;
        t_residue_result expected_q[$];
        int              mismatches;
        int              results_checked;
        int              inverse_faults;
        int              cmd_count[8];

        function new();
            modulus = VB'(MODULUS_RESET);
        endfunction

        function int ring_size();
            return (modulus < 2) ? 2 : int'(modulus);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // extended Euclid; the cofactor stays below m in magnitude
        function bit invert(input int x, input int m, output int inv);
            int r0, r1, t0, t1, q, tmp;
            r0 = m;
            r1 = x;
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q   = r0 / r1;
                tmp = r0 - q * r1;
                r0  = r1;
                r1  = tmp;
                tmp = t0 - q * t1;
                t0  = t1;
                t1  = tmp;
            end
            inv = 0;
            if (r0 != 1)
                return 1'b0;
            if (t0 < 0)
                t0 += m;
            inv = t0 % m;
            return 1'b1;
        endfunction

        // square-and-multiply, low bit first
        function int raise(input int base, input int mag, input int m);
            int acc;
            acc = 1 % m;
            while (mag != 0) begin
                if (mag & 1)
                    acc = (acc * base) % m;
                base = (base * base) % m;
                mag  = mag >> 1;
            end
            return acc;
        endfunction

        function void note_operands(input logic [CMD_W-1:0] cmd, input logic [VB-1:0] a,
                                    input logic [VB-1:0] b, input logic signed [EB-1:0] e);
            t_residue_result r;
            int m, ra, rb, inv, val, mag;
            bit fault;
            m     = ring_size();
            ra    = int'(a) % m;
            rb    = int'(b) % m;
            val   = 0;
            fault = 1'b0;
            mag   = (e < 0) ? -int'(e) : int'(e);
            case (cmd)
                CMD_ADD: val = (ra + rb) % m;
                CMD_SUB: val = (ra + m - rb) % m;
                CMD_MUL: val = (ra * rb) % m;
                CMD_DIV: begin
                    if (invert(rb, m, inv))
                        val = (ra * inv) % m;
                    else
                        fault = 1'b1;
                end
                CMD_POW: begin
                    if (e >= 0)
                        val = raise(ra, mag, m);
                    else if (invert(ra, m, inv))
                        val = raise(inv, mag, m);
                    else
                        fault = 1'b1;
                end
                CMD_INV: begin
                    if (invert(ra, m, inv))
                        val = inv;
                    else
                        fault = 1'b1;
                end
                default: val = 0;
            endcase
            if (fault)
                val = 0;
            r.value  = VB'(val);
            r.no_inv = fault;
            r.equal  = (ra == rb);
            r.less   = (ra < rb);
            expected_q.push_back(r);
            cmd_count[cmd]++;
            if (fault)
                inverse_faults++;
        endfunction

        function void check_result(input logic [VB-1:0] value, input logic [FLAG_W-1:0] flags);
            t_residue_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: value %0d flags %b",
                         $time, value, flags);
                mismatches++;
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            if (value !== exp_r.value) begin
                $display("%0t: result_value expected %0d actual %0d", $time, exp_r.value, value);
                mismatches++;
            end
            if (flags[FLAG_NO_INV] !== exp_r.no_inv) begin
                $display("%0t: no_inverse expected %b actual %b",
                         $time, exp_r.no_inv, flags[FLAG_NO_INV]);
                mismatches++;
            end
            if (flags[FLAG_EQUAL] !== exp_r.equal) begin
                $display("%0t: operands_equal expected %b actual %b",
                         $time, exp_r.equal, flags[FLAG_EQUAL]);
                mismatches++;
            end
            if (flags[FLAG_LESS] !== exp_r.less) begin
                $display("%0t: a_less_than_b expected %b actual %b",
                         $time, exp_r.less, flags[FLAG_LESS]);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // tdata: operand_a, operand_b, exponent (signed), zero padding
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    // tuser: command
    logic [CMD_W-1:0]   s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // tdata: result_value, zero padding
    logic [OUT_W-1:0]   m_axis_tdata;
    // tuser: no_inverse, operands_equal, a_less_than_b
    logic [FLAG_W-1:0]  m_axis_tuser;

    residue_scoreboard sb = new();
    int quiet_cycles = 0;
    int burst_left   = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int moduli[NUM_PHASES] = '{239, 2, 255, 0, 1, 251, 16, 7, 128, 239};

    modular_arithmetic_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Monitor both streams and count cycles without any beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_operands(s_axis_tuser, s_axis_tdata[VB-1:0], s_axis_tdata[2*VB-1:VB],
                             s_axis_tdata[2*VB+EB-1:2*VB]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[VB-1:0], m_axis_tuser);
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("modular_arithmetic_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sink: segments of random ready duty, plus long hold-offs on request
    // ------------------------------------------------------------------------
    initial begin : sink
        int seg_len, duty;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_asked > hold_served) begin
                hold_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                seg_len = $urandom_range(1, 40);
                case ($urandom_range(0, 2))
                    0:       duty = 100;
                    1:       duty = 70;
                    default: duty = 25;
                endcase
                repeat (seg_len) begin
                    m_axis_tready <= ($urandom_range(0, 99) < duty);
                    @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Source tasks
    // ------------------------------------------------------------------------
    // Offer one beat and hold it until taken; drop valid at the end of a burst
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [VB-1:0] a,
                              input logic [VB-1:0] b, input logic signed [EB-1:0] e);
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_W'({e, b, a});
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Lower valid after the last beat of a phase
    task automatic park_source();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // APB setup and access cycles
    task automatic write_modulus(input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.modulus = VB'(val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Operands biased toward zero, the modulus, one below it and all ones
    function automatic logic [VB-1:0] pick_operand(input int m);
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return VB'(m - 1);
            2:       return VB'(m);
            3:       return '1;
            default: return VB'($urandom_range(0, (1 << VB) - 1));
        endcase
    endfunction

    task automatic offer_random();
        logic [CMD_W-1:0]     cmd;
        logic [VB-1:0]        a, b;
        logic signed [EB-1:0] e;
        int                   m;
        m = sb.ring_size();
        if ($urandom_range(0, 11) == 0)
            cmd = CMD_W'($urandom_range(int'(CMD_SPARE_LO), int'(CMD_SPARE_HI)));
        else
            cmd = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_INV)));
        a = pick_operand(m);
        b = pick_operand(m);
        case ($urandom_range(0, 3))
            0:       e = EB'($urandom);
            1:       e = EB'($urandom_range(0, 40) - 20);
            2:       e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: e = EB'($urandom_range(0, 511) - 256);
        endcase
        offer_item(cmd, a, b, e);
    endtask

    // Corner items at the reset modulus
    task automatic run_directed();
        offer_item(CMD_ADD, 8'd255, 8'd255, 0);
        offer_item(CMD_ADD, 8'd238, 8'd238, 0);
        offer_item(CMD_SUB, 8'd0, 8'd255, 0);
        offer_item(CMD_SUB, 8'd255, 8'd0, -1);
        offer_item(CMD_MUL, 8'd255, 8'd255, 0);
        offer_item(CMD_MUL, 8'd0, 8'd200, 0);
        // divide by a zero residue, raw and after reduction
        offer_item(CMD_DIV, 8'd10, 8'd0, 0);
        offer_item(CMD_DIV, 8'd239, 8'd239, 0);
        offer_item(CMD_DIV, 8'd100, 8'd3, 0);
        offer_item(CMD_DIV, 8'd255, 8'd255, 0);
        // inverse of zero and of the edges of the ring
        offer_item(CMD_INV, 8'd0, 8'd1, 0);
        offer_item(CMD_INV, 8'd1, 8'd0, 0);
        offer_item(CMD_INV, 8'd238, 8'd255, 0);
        offer_item(CMD_INV, 8'd239, 8'd2, 0);
        // zero exponent on a zero base, negative exponent on a zero base
        offer_item(CMD_POW, 8'd0, 8'd0, 0);
        offer_item(CMD_POW, 8'd0, 8'd9, -1);
        offer_item(CMD_POW, 8'd0, 8'd9, 5);
        offer_item(CMD_POW, 8'd255, 8'd4, 32767);
        offer_item(CMD_POW, 8'd2, 8'd4, -32768);
        offer_item(CMD_POW, 8'd7, 8'd7, -1);
        offer_item(CMD_POW, 8'd238, 8'd0, 1);
        // unused command codes still report the compare flags
        offer_item(CMD_SPARE_LO, 8'd3, 8'd3, 0);
        offer_item(CMD_SPARE_HI, 8'd5, 8'd200, -32768);
        park_source();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_drained();
                write_modulus(moduli[phase]);
            end
            // fill the block while the sink holds off
            if (phase == 5)
                hold_asked++;
            repeat (PER_PHASE) offer_random();
            park_source();
        end
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results: add %0d, sub %0d, mul %0d, div %0d,",
                 sb.results_checked, sb.cmd_count[CMD_ADD], sb.cmd_count[CMD_SUB],
                 sb.cmd_count[CMD_MUL], sb.cmd_count[CMD_DIV]);
        $display("  pow %0d, inv %0d, spare %0d; swept %0d moduli, %0d missing inverses, %0d hold-offs",
                 sb.cmd_count[CMD_POW], sb.cmd_count[CMD_INV],
                 sb.cmd_count[CMD_SPARE_LO] + sb.cmd_count[CMD_SPARE_HI],
                 NUM_PHASES, sb.inverse_faults, hold_served);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("modular_arithmetic_unit test passed");
        end else begin
            $display("%0t: %0d mismatches, %0d results still expected",
                     $time, sb.mismatches, sb.pending());
            $display("modular_arithmetic_unit test failed");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/mau_pkg.sv
sv/modular_arithmetic_unit.sv
tb/modular_arithmetic_unit_tb.sv
